/* hw/rtl/apsm_pkg.sv */
`default_nettype none
package apsm_pkg;

   // Sizing
   localparam int CHANNELS            = 4;
   localparam int SAMPLES_PER_CHANNEL = 8;
   localparam int TABLE_POINTS        = 5;

   localparam int CH_W     = $clog2(CHANNELS);
   localparam int PTR_W    = $clog2(SAMPLES_PER_CHANNEL);
   localparam int SLOTS    = CHANNELS * SAMPLES_PER_CHANNEL;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int SEGMENTS = TABLE_POINTS - 1;
   localparam int SEG_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int PT_W     = $clog2(TABLE_POINTS);

   // Word fields
   localparam int CHAN_IDX_W = 2;
   localparam int SAMPLE_W   = 12;
   localparam int SUM_W      = SAMPLE_W + PTR_W;
   localparam int VOLT_W     = 15;
   localparam int FINE_W     = 12;
   localparam int FINE_FRAC  = 4;
   localparam int WHOLE_W    = 8;
   localparam int LEVEL_W    = 3;
   localparam int LIMIT_W    = 8;
   localparam int CSR_IDX_W  = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_ONE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_TWO   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_THREE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_FOUR  = 4'd3;

   // Speed levels
   localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = 3'd4;
   localparam logic [LEVEL_W-1:0] LEVEL_FIVE  = 3'd5;

   // Battery: volts*256 = 15488*avg/4095 - 256
   localparam int BT_GAIN_W = 14;
   localparam int BT_W      = SAMPLE_W + BT_GAIN_W;
   localparam int BM_W      = 27;
   localparam int BP_W      = BT_W + BM_W;
   localparam int BQ_W      = 14;
   localparam int BATT_SHIFT = 38;
   localparam logic [BT_GAIN_W-1:0] BATT_GAIN   = 14'd15488;
   localparam logic [BM_W-1:0]      BATT_RECIP  = 27'd67125252;  // floor(2^38 / 4095)
   localparam logic [SAMPLE_W-1:0]  BATT_DIV    = 12'd4095;
   localparam logic [BQ_W-1:0]      BATT_OFFSET = 14'd256;

   // Pressure map
   localparam int RISE_W  = 9;
   localparam int RECIP_W = 23;
   localparam int PN_W    = 19;
   localparam int PP_W    = PN_W + RECIP_W;
   localparam int PQ_W    = 9;
   localparam int PSHIFT  = 32;

   localparam logic [SAMPLE_W-1:0] MAP_ADC [TABLE_POINTS] =
      '{12'd0, 12'd1300, 12'd2000, 12'd2600, 12'd3450};
   localparam logic [FINE_W-1:0] MAP_FINE [TABLE_POINTS] =
      '{12'd1600, 12'd2000, 12'd2400, 12'd2800, 12'd3200};
   localparam logic [SAMPLE_W-1:0] SEG_SPAN [SEGMENTS] =
      '{12'd1300, 12'd700, 12'd600, 12'd850};
   localparam logic [RISE_W-1:0] SEG_RISE [SEGMENTS] =
      '{9'd400, 9'd400, 9'd400, 9'd400};
   // floor(2^32 / span)
   localparam logic [RECIP_W-1:0] SEG_RECIP [SEGMENTS] =
      '{23'd3303820, 23'd6135667, 23'd7158278, 23'd5052902};

   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
      logic load4;
      logic load_out;
   } adv_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] level_one_limit;
      logic [LIMIT_W-1:0] level_two_limit;
      logic [LIMIT_W-1:0] level_three_limit;
      logic [LIMIT_W-1:0] level_four_limit;
   } limits_type;

endpackage
`default_nettype wire

/* hw/rtl/apsm_chan_if.sv */
`default_nettype none
interface apsm_req_if import apsm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAN_IDX_W-1:0] channel_index;
   logic [SAMPLE_W-1:0]   raw_sample;

   modport source (output valid, output channel_index, output raw_sample, input ready);
   modport sink   (input valid, input channel_index, input raw_sample, output ready);
endinterface

interface apsm_rsp_if import apsm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [VOLT_W-1:0] battery_volts;
   logic [FINE_W-1:0]        pressure_fine;
   logic [WHOLE_W-1:0]       pressure_whole;
   logic [LEVEL_W-1:0]       speed_level;

   modport source (output valid, output battery_volts, output pressure_fine,
                   output pressure_whole, output speed_level, input ready);
   modport sink   (input valid, input battery_volts, input pressure_fine,
                   input pressure_whole, input speed_level, output ready);
endinterface

interface apsm_csr_if import apsm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [LIMIT_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/apsm_store.sv */
`default_nettype none
module apsm_store import apsm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire adv_type               adv,
   input  wire logic [CHAN_IDX_W-1:0] channel_index,
   input  wire logic [SAMPLE_W-1:0]   raw_sample,
   output logic      [SAMPLE_W-1:0]   avg0,
   output logic      [SAMPLE_W-1:0]   avg1
);

   logic [SAMPLE_W-1:0] hist_ff [SLOTS];
   logic [SUM_W-1:0]    sums_ff [CHANNELS];
   logic [SUM_W-1:0]    sums_in [CHANNELS];
   logic [PTR_W-1:0]    ptrs_ff [CHANNELS];
   logic [PTR_W-1:0]    ptrs_in [CHANNELS];
   logic [SAMPLE_W-1:0] avg0_ff, avg1_ff;
   logic [CH_W-1:0]     ch_idx;
   logic                in_range;
   logic [SLOT_W-1:0]   slot;
   logic [SAMPLE_W-1:0] oldest;

   // Replace the oldest sample of the channel and adjust its sum.
   always_comb begin
      ch_idx   = CH_W'(channel_index);
      in_range = (int'(channel_index) < CHANNELS);
      slot     = SLOT_W'(ch_idx) * SLOT_W'(SAMPLES_PER_CHANNEL) + SLOT_W'(ptrs_ff[ch_idx]);
      oldest   = hist_ff[slot];
      sums_in  = sums_ff;
      ptrs_in  = ptrs_ff;
      if (in_range) begin
         sums_in[ch_idx] = sums_ff[ch_idx] - SUM_W'(oldest) + SUM_W'(raw_sample);
         ptrs_in[ch_idx] = (int'(ptrs_ff[ch_idx]) == SAMPLES_PER_CHANNEL - 1) ? '0
                                                   : ptrs_ff[ch_idx] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) hist_ff[i] <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            sums_ff[i] <= '0;
            ptrs_ff[i] <= '0;
         end
      end else if (adv.load1) begin
         if (in_range) hist_ff[slot] <= raw_sample;
         sums_ff <= sums_in;
         ptrs_ff <= ptrs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.load1) begin
         avg0_ff <= SAMPLE_W'(sums_in[0] >> PTR_W);
         avg1_ff <= SAMPLE_W'(sums_in[1] >> PTR_W);
      end
   end

   assign avg0 = avg0_ff;
   assign avg1 = avg1_ff;

endmodule
`default_nettype wire

/* hw/rtl/apsm_batt.sv */
`default_nettype none
module apsm_batt import apsm_pkg::*; (
   input  wire logic                     clock,
   input  wire adv_type                  adv,
   input  wire logic [SAMPLE_W-1:0]      avg0,
   output logic signed [VOLT_W-1:0]      battery_volts
);

   logic [BT_W-1:0]          t2_ff, t3_ff;
   logic [BP_W-1:0]          prod3;
   logic [BQ_W-1:0]          q3_ff, q3_in;
   logic [BQ_W-1:0]          q4_ff, q4_in;
   logic                     neg4_ff, neg4_in;
   logic [BT_W-1:0]          rem, rem_c;
   logic signed [VOLT_W-1:0] volts_ff;

   // Quotient estimate from the reciprocal is exact or one low.
   always_comb begin
      prod3 = BP_W'(t2_ff) * BP_W'(BATT_RECIP);
      q3_in = prod3[BATT_SHIFT +: BQ_W];
   end

   // Correct the quotient; a negative result with a remainder rounds up toward zero.
   always_comb begin
      rem   = t3_ff - BT_W'(q3_ff) * BT_W'(BATT_DIV);
      q4_in = q3_ff;
      rem_c = rem;
      if (rem >= BT_W'(BATT_DIV)) begin
         q4_in = q3_ff + 1'b1;
         rem_c = rem - BT_W'(BATT_DIV);
      end
      neg4_in = (q4_in < BATT_OFFSET) && (rem_c != '0);
   end

   always_ff @(posedge clock) begin
      if (adv.load2) t2_ff <= BT_W'(avg0) * BT_W'(BATT_GAIN);
      if (adv.load3) begin
         t3_ff <= t2_ff;
         q3_ff <= q3_in;
      end
      if (adv.load4) begin
         q4_ff   <= q4_in;
         neg4_ff <= neg4_in;
      end
      if (adv.load_out)
         volts_ff <= VOLT_W'(q4_ff) - VOLT_W'(BATT_OFFSET) + VOLT_W'(neg4_ff);
   end

   assign battery_volts = volts_ff;

endmodule
`default_nettype wire

/* hw/rtl/apsm_press.sv */
`default_nettype none
module apsm_press import apsm_pkg::*; (
   input  wire logic                clock,
   input  wire adv_type             adv,
   input  wire limits_type          limits,
   input  wire logic [SAMPLE_W-1:0] avg1,
   output logic      [FINE_W-1:0]   pressure_fine,
   output logic      [WHOLE_W-1:0]  pressure_whole,
   output logic      [LEVEL_W-1:0]  speed_level
);

   logic [SEG_W-1:0]    seg2_in, seg2_ff, seg3_ff, seg4_ff;
   logic                lo2_in, hi2_in;
   logic                lo2_ff, hi2_ff, lo3_ff, hi3_ff, lo4_ff, hi4_ff;
   logic [SAMPLE_W-1:0] seg_offset;
   logic [PN_W-1:0]     n2_in, n2_ff, n3_ff;
   logic [PP_W-1:0]     prod3;
   logic [PQ_W-1:0]     pq3_in, pq3_ff, pq4_in, pq4_ff;
   logic [PN_W-1:0]     rem;
   logic [FINE_W-1:0]   fine_in, fine_ff;
   logic [WHOLE_W-1:0]  whole_in, whole_ff;
   logic [LEVEL_W-1:0]  level_in, level_ff;

   // Pick the segment, scale the offset into it by the segment's rise.
   always_comb begin
      lo2_in  = (avg1 <= MAP_ADC[0]);
      hi2_in  = (avg1 >= MAP_ADC[TABLE_POINTS-1]);
      seg2_in = '0;
      for (int k = 1; k < TABLE_POINTS - 1; k++)
         if (avg1 > MAP_ADC[k]) seg2_in = seg2_in + 1'b1;
      seg_offset = avg1 - MAP_ADC[PT_W'(seg2_in)];
      n2_in      = PN_W'(PN_W'(seg_offset) * PN_W'(SEG_RISE[seg2_in]));
   end

   always_comb begin
      prod3  = PP_W'(n2_ff) * PP_W'(SEG_RECIP[seg2_ff]);
      pq3_in = prod3[PSHIFT +: PQ_W];
   end

   always_comb begin
      rem    = n3_ff - PN_W'(PN_W'(pq3_ff) * PN_W'(SEG_SPAN[seg3_ff]));
      pq4_in = (rem >= PN_W'(SEG_SPAN[seg3_ff])) ? pq3_ff + 1'b1 : pq3_ff;
   end

   // Clamp at both ends, then map whole MPa to a speed level.
   always_comb begin
      if (lo4_ff)      fine_in = MAP_FINE[0];
      else if (hi4_ff) fine_in = MAP_FINE[TABLE_POINTS-1];
      else             fine_in = MAP_FINE[PT_W'(seg4_ff)] + FINE_W'(pq4_ff);
      whole_in = WHOLE_W'(fine_in >> FINE_FRAC);
      if (whole_in <= limits.level_one_limit)        level_in = LEVEL_ONE;
      else if (whole_in <= limits.level_two_limit)   level_in = LEVEL_TWO;
      else if (whole_in <= limits.level_three_limit) level_in = LEVEL_THREE;
      else if (whole_in <= limits.level_four_limit)  level_in = LEVEL_FOUR;
      else                                           level_in = LEVEL_FIVE;
   end

   always_ff @(posedge clock) begin
      if (adv.load2) begin
         n2_ff   <= n2_in;
         seg2_ff <= seg2_in;
         lo2_ff  <= lo2_in;
         hi2_ff  <= hi2_in;
      end
      if (adv.load3) begin
         n3_ff   <= n2_ff;
         seg3_ff <= seg2_ff;
         lo3_ff  <= lo2_ff;
         hi3_ff  <= hi2_ff;
         pq3_ff  <= pq3_in;
      end
      if (adv.load4) begin
         seg4_ff <= seg3_ff;
         lo4_ff  <= lo3_ff;
         hi4_ff  <= hi3_ff;
         pq4_ff  <= pq4_in;
      end
      if (adv.load_out) begin
         fine_ff  <= fine_in;
         whole_ff <= whole_in;
         level_ff <= level_in;
      end
   end

   assign pressure_fine  = fine_ff;
   assign pressure_whole = whole_ff;
   assign speed_level    = level_ff;

endmodule
`default_nettype wire

/* hw/rtl/adc_average_piecewise_speed_map_core.sv */
// Throughput: one sample word per cycle while rsp_chan.ready holds; five register
//    stages, each with its own valid bit, so a bubble anywhere lets a new word in
//    while a result waits.
// Reset (synchronous, active high): clears sample history, sums, pointers and valid
//    bits, and loads the level limits with 120, 140, 160 and 180.
`default_nettype none
module adc_average_piecewise_speed_map_core import apsm_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   apsm_req_if.sink    req_chan,
   apsm_rsp_if.source  rsp_chan,
   apsm_csr_if.sink    csr_chan
);

   localparam logic [LIMIT_W-1:0] LIMIT_ONE_RESET   = 8'd120;
   localparam logic [LIMIT_W-1:0] LIMIT_TWO_RESET   = 8'd140;
   localparam logic [LIMIT_W-1:0] LIMIT_THREE_RESET = 8'd160;
   localparam logic [LIMIT_W-1:0] LIMIT_FOUR_RESET  = 8'd180;

   // Stage valid bits: 1 = averages, 2 = first products, 3 = reciprocal products,
   // 4 = corrected quotients; rsp_valid_ff marks the output register.
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en_out;
   logic accept;
   adv_type    adv;
   limits_type limits_ff;

   logic [SAMPLE_W-1:0] avg0, avg1;

   // A stage may load when it is empty or its content moves on this cycle.
   always_comb begin
      en_out = !rsp_valid_ff || rsp_chan.ready;
      en4    = !v4_ff || en_out;
      en3    = !v3_ff || en4;
      en2    = !v2_ff || en3;
      en1    = !v1_ff || en2;
      accept = req_chan.valid && en1;

      adv.load1    = accept;
      adv.load2    = en2 && v1_ff;
      adv.load3    = en3 && v2_ff;
      adv.load4    = en4 && v3_ff;
      adv.load_out = en_out && v4_ff;
   end

   assign req_chan.ready = en1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff        <= accept;
         if (en2)    v2_ff        <= v1_ff;
         if (en3)    v3_ff        <= v2_ff;
         if (en4)    v4_ff        <= v3_ff;
         if (en_out) rsp_valid_ff <= v4_ff;
      end
   end

   // Limit registers; drop writes to indexes past the last limit.
   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.level_one_limit   <= LIMIT_ONE_RESET;
         limits_ff.level_two_limit   <= LIMIT_TWO_RESET;
         limits_ff.level_three_limit <= LIMIT_THREE_RESET;
         limits_ff.level_four_limit  <= LIMIT_FOUR_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_LEVEL_ONE:   limits_ff.level_one_limit   <= csr_chan.data;
            CSR_LEVEL_TWO:   limits_ff.level_two_limit   <= csr_chan.data;
            CSR_LEVEL_THREE: limits_ff.level_three_limit <= csr_chan.data;
            CSR_LEVEL_FOUR:  limits_ff.level_four_limit  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // History update and post-update averages of channels 0 and 1.
   apsm_store u_store (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .channel_index (req_chan.channel_index),
      .raw_sample    (req_chan.raw_sample),
      .avg0          (avg0),
      .avg1          (avg1)
   );

   // Battery voltage: gain, reciprocal divide by 4095, truncate toward zero.
   apsm_batt u_batt (
      .clock         (clock),
      .adv           (adv),
      .avg0          (avg0),
      .battery_volts (rsp_chan.battery_volts)
   );

   // Pressure interpolation and speed level.
   apsm_press u_press (
      .clock          (clock),
      .adv            (adv),
      .limits         (limits_ff),
      .avg1           (avg1),
      .pressure_fine  (rsp_chan.pressure_fine),
      .pressure_whole (rsp_chan.pressure_whole),
      .speed_level    (rsp_chan.speed_level)
   );

`ifndef NO_ASSERTIONS
   a_level_range : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.speed_level >= LEVEL_ONE &&
                          rsp_chan.speed_level <= LEVEL_FIVE))
      else $error("speed level out of range");

   a_whole_matches_fine : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pressure_whole ==
                          WHOLE_W'(rsp_chan.pressure_fine >> FINE_FRAC)))
      else $error("whole pressure does not match fine pressure");

   a_fine_clamped : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pressure_fine >= MAP_FINE[0] &&
                          rsp_chan.pressure_fine <= MAP_FINE[TABLE_POINTS-1]))
      else $error("fine pressure outside table range");

   a_accept_fills_stage : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> v1_ff)
      else $error("accepted word lost at first stage");
`endif

endmodule
`default_nettype wire
